@@ sv/assert_macros.svh @@
// assertion macros used by the scanner top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define WBPS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wbps: same-cycle check failed");

// next-cycle implication, disabled during reset
`define WBPS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wbps: next-cycle check failed");

`endif

@@ sv/wbps_pkg.sv @@
// types and constants of the wildcard byte pattern scanner
package wbps_pkg;

    localparam int PAT_SLOTS     = 16;
    localparam int LEN_BITS      = 5;
    localparam int ADDR_BITS     = 64;
    localparam int CFG_DATA_BITS = 64;
    localparam int CFG_IDX_BITS  = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PAT_LOW   = 3'd0,
        CFG_PAT_HIGH  = 3'd1,
        CFG_WILD_MASK = 3'd2,
        CFG_PAT_LEN   = 3'd3,
        CFG_BASE_ADDR = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_range;
    } in_beat_t;

    typedef struct packed {
        logic                 match_found;
        logic                 not_found;
        logic [ADDR_BITS-1:0] match_address;
    } out_beat_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic                step;
        logic                clear;
        logic [7:0]          data_byte;
        logic [LEN_BITS-1:0] eff_len;
    } cell_bcast_t;

endpackage

@@ sv/wbps_in_if.sv @@
// input byte channel
interface wbps_in_if;
    import wbps_pkg::*;

    logic     valid;
    logic     ready;
    in_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ sv/wbps_out_if.sv @@
// result channel
interface wbps_out_if;
    import wbps_pkg::*;

    logic      valid;
    logic      ready;
    out_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ sv/wbps_cell.sv @@
// one pattern position of the shift-and match row
module wbps_cell #(
    parameter int IDX = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  wbps_pkg::cell_bcast_t bcast,
    input  logic [7:0]            pat_byte,
    input  logic                  wild,
    input  logic                  prev_bit,
    output logic                  bit_q,
    output logic                  tail_hit
);
    import wbps_pkg::*;

    logic bit_reg;
    logic bit_next;
    logic hit;
    logic live;
    logic new_bit;

    assign hit      = wild | (pat_byte == bcast.data_byte);
    assign live     = bcast.eff_len > LEN_BITS'(IDX);
    assign new_bit  = prev_bit & hit & live;
    // this cell is the final pattern position
    assign tail_hit = new_bit & (bcast.eff_len == LEN_BITS'(IDX + 1));

    always_comb
    begin
        bit_next = bit_reg;
        if (bcast.step)
        begin
            bit_next = bcast.clear ? 1'b0 : new_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg <= 1'b0;
        end
        else
        begin
            bit_reg <= bit_next;
        end
    end

    assign bit_q = bit_reg;

endmodule

@@ sv/wildcard_byte_pattern_scan_top.sv @@
// top level of the wildcard byte pattern scanner
`include "assert_macros.svh"

// Scans a byte stream for the first occurrence of a pattern of up to 16 bytes,
// any position of which may be a wildcard. One byte beat is taken per clock
// cycle while the result register is free or drained, and each byte gives
// exactly one result beat, registered in the cycle after the byte is taken.
// Each cell takes its partial-match bit from its left neighbor. The first
// full match of a range reports base_address plus the offset of its first
// byte; the beat that carries end_of_range reports not_found when the range
// had no match, and the scan then restarts at offset zero. Later bytes of a
// range after a match give all-zero results. A pattern length of zero never
// matches; lengths above the cell count are clamped. Configuration is taken
// through a plain write port and should be written while the block is idle.
module wildcard_byte_pattern_scan_top #(
    parameter int MAX_PATTERN_BYTES = 16,
    parameter int OFFSET_BITS       = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    wbps_in_if.sink                            byte_stream,
    wbps_out_if.source                         result,
    input  logic                               cfg_we,
    input  logic [wbps_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [wbps_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import wbps_pkg::*;

    // cells beyond the pattern registers could never be live
    localparam int NCELLS = (MAX_PATTERN_BYTES < PAT_SLOTS) ? MAX_PATTERN_BYTES : PAT_SLOTS;

    // configuration registers
    logic [63:0]          pat_low_reg;
    logic [63:0]          pat_high_reg;
    logic [15:0]          wild_mask_reg;
    logic [LEN_BITS-1:0]  pat_len_reg;
    logic [ADDR_BITS-1:0] base_addr_reg;

    // scan state
    logic [OFFSET_BITS-1:0] offset_reg;
    logic [OFFSET_BITS-1:0] offset_next;
    logic                   found_reg;
    logic                   found_next;

    // output stage
    logic      out_valid_reg;
    logic      out_valid_next;
    out_beat_t out_data_reg;
    out_beat_t out_data_next;

    logic                 accept;
    logic                 last_byte;
    logic [LEN_BITS-1:0]  eff_len;
    logic [LEN_BITS-1:0]  eff_len_m1;
    logic [127:0]         pat_all;
    logic [NCELLS-1:0]    cell_bits;
    logic [NCELLS-1:0]    tail_hits;
    logic                 match_now;
    logic [ADDR_BITS-1:0] start_addr;
    cell_bcast_t          bcast;

    // ---------------------------------------------------------------
    // configuration write port
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg   <= '0;
            pat_high_reg  <= '0;
            wild_mask_reg <= '0;
            pat_len_reg   <= '0;
            base_addr_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_PAT_LOW:   pat_low_reg   <= cfg_data;
                CFG_PAT_HIGH:  pat_high_reg  <= cfg_data;
                CFG_WILD_MASK: wild_mask_reg <= cfg_data[15:0];
                CFG_PAT_LEN:   pat_len_reg   <= cfg_data[LEN_BITS-1:0];
                CFG_BASE_ADDR: base_addr_reg <= cfg_data;
                default:       ; // unused indexes are ignored
            endcase
        end
    end

    // ---------------------------------------------------------------
    // handshake: a new byte enters whenever the result register is free
    // or being drained in this same cycle
    // ---------------------------------------------------------------
    assign byte_stream.ready = !out_valid_reg || result.ready;
    assign accept            = byte_stream.valid && byte_stream.ready;
    assign last_byte         = byte_stream.data.end_of_range;

    // clamp the length to the cells that exist
    assign eff_len    = (pat_len_reg > LEN_BITS'(NCELLS)) ? LEN_BITS'(NCELLS) : pat_len_reg;
    assign eff_len_m1 = eff_len - LEN_BITS'(1);

    assign bcast.step      = accept;
    assign bcast.clear     = last_byte;
    assign bcast.data_byte = byte_stream.data.data_byte;
    assign bcast.eff_len   = eff_len;

    assign pat_all = {pat_high_reg, pat_low_reg};

    // ---------------------------------------------------------------
    // row of match cells; cell i sees the old bit of cell i-1, cell 0
    // always starts a fresh candidate
    // ---------------------------------------------------------------
    for (genvar gi = 0; gi < NCELLS; gi++)
    begin : g_cell
        logic prev;

        if (gi == 0)
        begin : g_head
            assign prev = 1'b1;
        end
        else
        begin : g_body
            assign prev = cell_bits[gi-1];
        end

        wbps_cell #(
            .IDX (gi)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .bcast    (bcast),
            .pat_byte (pat_all[8*gi +: 8]),
            .wild     (wild_mask_reg[gi]),
            .prev_bit (prev),
            .bit_q    (cell_bits[gi]),
            .tail_hit (tail_hits[gi])
        );
    end

    // only the first full match of a range counts
    assign match_now  = (|tail_hits) && !found_reg;
    assign start_addr = base_addr_reg + ADDR_BITS'(offset_reg) - ADDR_BITS'(eff_len_m1);

    // ---------------------------------------------------------------
    // offset and already-found tracking
    // ---------------------------------------------------------------
    always_comb
    begin
        offset_next = offset_reg;
        found_next  = found_reg;
        if (accept)
        begin
            if (last_byte)
            begin
                offset_next = '0;
                found_next  = 1'b0;
            end
            else
            begin
                offset_next = offset_reg + OFFSET_BITS'(1);
                found_next  = found_reg | match_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            found_reg  <= 1'b0;
        end
        else
        begin
            offset_reg <= offset_next;
            found_reg  <= found_next;
        end
    end

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (accept)
        begin
            out_valid_next              = 1'b1;
            out_data_next.match_found   = match_now;
            out_data_next.not_found     = last_byte && !found_reg && !match_now;
            out_data_next.match_address = match_now ? start_addr : '0;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    `WBPS_ASSERT_IMP(a_found_excludes_missing, clk, rst_n,
        out_valid_reg && out_data_reg.match_found, !out_data_reg.not_found)
    `WBPS_ASSERT_IMP(a_addr_zero_without_match, clk, rst_n,
        out_valid_reg && !out_data_reg.match_found, out_data_reg.match_address == '0)
    `WBPS_ASSERT_NXT(a_range_end_restarts, clk, rst_n,
        accept && last_byte, (offset_reg == '0) && !found_reg && (cell_bits == '0))
    `WBPS_ASSERT_NXT(a_single_match_per_range, clk, rst_n,
        accept && found_reg, !out_data_reg.match_found && !out_data_reg.not_found)

endmodule

@@ verif/wildcard_byte_pattern_scan_top_test.sv @@
// self-checking testbench for the wildcard byte pattern scanner
`timescale 1ns / 1ps

module wildcard_byte_pattern_scan_top_test;
    import wbps_pkg::*;

    // receiver hold-off length, quiet-cycle limit and settle time after the last beat
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int RANDOM_PHASES  = 15;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    wbps_in_if  byte_if ();
    wbps_out_if result_if ();

    wildcard_byte_pattern_scan_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_if),
        .result      (result_if),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // shadow copy of the configuration registers
    logic [63:0] pat_lo = '0;
    logic [63:0] pat_hi = '0;
    logic [15:0] wild_mask = '0;
    logic [4:0]  pat_len = '0;
    logic [63:0] base_addr = '0;

    // scan state: live prefix vector, offset in the range, first match seen
    logic [15:0] live_prefixes = '0;
    logic [31:0] range_offset = '0;
    logic        match_reported = 1'b0;

    in_beat_t  pending_bytes[$];
    out_beat_t expected_results[$];

    int bytes_queued = 0;
    int bytes_accepted = 0;
    int error_count = 0;
    int ranges_closed = 0;
    int first_matches = 0;
    int empty_ranges = 0;
    int settings_used = 0;

    // idle rates in percent, set per phase
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // long receiver hold-off: the stimulus bumps the request, the receiver counts it out
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;

    int quiet_cycles = 0;

    // byte alphabet of the current pattern, reused for background bytes
    logic [7:0] symbols[3];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // pattern length in use, clamped to the cell count
    function automatic int active_len();
        return (pat_len > 5'd16) ? 16 : int'(pat_len);
    endfunction

    function automatic logic [7:0] pat_at(int pos);
        return (pos < 8) ? pat_lo[8*pos +: 8] : pat_hi[8*(pos-8) +: 8];
    endfunction

    // advance the shift-and scan by one byte and return the result beat it gives
    function automatic out_beat_t scan_step(logic [7:0] value, logic range_end);
        int          n;
        int          i;
        logic [15:0] hits;
        logic [15:0] live;
        out_beat_t   res;

        n = active_len();
        live = (n == 16) ? 16'hFFFF : ((16'h1 << n) - 16'h1);
        hits = '0;
        for (i = 0; i < n; i++)
        begin
            if (wild_mask[i] || pat_at(i) == value)
                hits[i] = 1'b1;
        end
        live_prefixes = ((live_prefixes << 1) | 16'h1) & hits & live;

        res = '0;
        // only the first completed match of a range is reported
        if (!match_reported && n != 0 && live_prefixes[n-1])
        begin
            res.match_found = 1'b1;
            res.match_address = base_addr + 64'(range_offset) - 64'(n - 1);
            match_reported = 1'b1;
        end

        if (range_end)
        begin
            res.not_found = !match_reported;
            live_prefixes = '0;
            range_offset = '0;
            match_reported = 1'b0;
        end
        else
        begin
            range_offset = range_offset + 32'd1;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // configuration port, used only while the scanner is idle
    // ------------------------------------------------------------------

    task automatic write_reg(cfg_reg_t idx, logic [63:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            CFG_PAT_LOW:   pat_lo = value;
            CFG_PAT_HIGH:  pat_hi = value;
            CFG_WILD_MASK: wild_mask = value[15:0];
            CFG_PAT_LEN:   pat_len = value[4:0];
            CFG_BASE_ADDR: base_addr = value;
            default:       ;
        endcase
    endtask

    // drop the write enable, then hand back at a falling edge
    task automatic close_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // append one beat to the pending byte queue
    task automatic add_pending(in_beat_t beat);
        pending_bytes.insert(pending_bytes.size(), beat);
    endtask

    // queue one byte; ranges also end at random so some patterns get cut off
    task automatic queue_byte(logic [7:0] value, logic force_end);
        in_beat_t beat;
        beat.data_byte = value;
        beat.end_of_range = force_end || ($urandom_range(29) == 0);
        add_pending(beat);
        bytes_queued++;
    endtask

    // sender pause: nothing new until every expected result beat is back
    task automatic wait_for_drain();
        while (bytes_accepted != bytes_queued || expected_results.size() != 0)
            @(negedge clk);
    endtask

    // pick a pattern, wildcards, length and base, and load all five registers
    task automatic new_pattern();
        int          i;
        int          len;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mask_val;
        logic [63:0] len_val;
        logic [63:0] base_val;
        logic [7:0]  b;

        // a small alphabet makes overlapping candidates common
        for (i = 0; i < 3; i++)
            symbols[i] = 8'($urandom);
        lo = '0;
        hi = '0;
        for (i = 0; i < 16; i++)
        begin
            b = ($urandom_range(4) == 0) ? 8'($urandom) : symbols[$urandom_range(2)];
            if (i < 8)
                lo[8*i +: 8] = b;
            else
                hi[8*(i-8) +: 8] = b;
        end

        case ($urandom_range(9))
            0:       len = 0;
            1:       len = 1;
            2:       len = 16;
            3:       len = $urandom_range(31, 17);
            default: len = $urandom_range(10, 2);
        endcase
        len_val = 64'(len);
        if ($urandom_range(1) == 0)
            len_val = {27'($urandom), $urandom, 5'(len)};

        case ($urandom_range(4))
            0:       mask_val = '0;
            1:       mask_val = 64'hFFFF;
            2:       mask_val = 64'($urandom & $urandom & $urandom);
            default: mask_val = 64'($urandom);
        endcase
        if ($urandom_range(1) == 0)
            mask_val[63:16] = 48'({$urandom, $urandom});

        case ($urandom_range(4))
            0:       base_val = '0;
            1:       base_val = '1;
            2:       base_val = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(40));
            default: base_val = {$urandom, $urandom};
        endcase

        write_reg(CFG_PAT_LOW, lo);
        write_reg(CFG_PAT_HIGH, hi);
        write_reg(CFG_WILD_MASK, mask_val);
        write_reg(CFG_PAT_LEN, len_val);
        write_reg(CFG_BASE_ADDR, base_val);
        close_writes();
    endtask

    // mostly full or cut-short copies of the pattern among alphabet and noise bytes
    task automatic fill_stream(int count);
        int         made;
        int         k;
        int         cut;
        int         i;
        int         pick;
        logic [7:0] b;

        made = 0;
        while (made < count)
        begin
            k = active_len();
            if (k > 0 && $urandom_range(99) < 30)
            begin
                cut = ($urandom_range(3) == 0) ? $urandom_range(k - 1) : k;
                for (i = 0; i < cut && made < count; i++)
                begin
                    b = wild_mask[i] ? 8'($urandom) : pat_at(i);
                    // sometimes close the range right on the matching byte
                    queue_byte(b, (cut == k) && (i == cut - 1) && ($urandom_range(3) == 0));
                    made++;
                end
            end
            else
            begin
                pick = $urandom_range(9);
                if (pick < 5)
                    b = symbols[$urandom_range(2)];
                else if (pick < 7 && k > 0)
                    b = pat_at($urandom_range(k - 1));
                else
                    b = 8'($urandom);
                queue_byte(b, 1'b0);
                made++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // byte driver: keeps offering from the pending queue, idles at random
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_if.valid <= 1'b0;
            byte_if.data <= '0;
        end
        else if (!byte_if.valid || byte_if.ready)
        begin
            if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                byte_if.valid <= 1'b1;
                byte_if.data <= pending_bytes.pop_front();
            end
            else
            begin
                byte_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // result receiver: random stalls plus the occasional long hold-off
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
        end
        else
        begin
            if (hold_seen != hold_req)
            begin
                hold_seen = hold_req;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_if.ready <= 1'b0;
            end
            else
            begin
                result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: predict on every accepted byte, check every result beat
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : result_check
        out_beat_t want;
        out_beat_t got;

        if (rst_n)
        begin
            // byte side first, so a result given in the same cycle as its byte would still find its entry
            if (byte_if.valid && byte_if.ready)
            begin
                want = scan_step(byte_if.data.data_byte, byte_if.data.end_of_range);
                expected_results.insert(expected_results.size(), want);
                bytes_accepted++;
                if (byte_if.data.end_of_range)
                    ranges_closed++;
                if (want.match_found)
                    first_matches++;
                if (want.not_found)
                    empty_ranges++;
            end

            if (result_if.valid && result_if.ready)
            begin
                got = result_if.data;
                if (expected_results.size() == 0)
                begin
                    $error("result beat with nothing expected: match_found %0b not_found %0b addr %h",
                           got.match_found, got.not_found, got.match_address);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.match_found !== want.match_found)
                    begin
                        $error("match_found: expected %0b, got %0b",
                               want.match_found, got.match_found);
                        error_count++;
                    end
                    if (got.not_found !== want.not_found)
                    begin
                        $error("not_found: expected %0b, got %0b",
                               want.not_found, got.not_found);
                        error_count++;
                    end
                    if (got.match_address !== want.match_address)
                    begin
                        $error("match_address: expected %h, got %h",
                               want.match_address, got.match_address);
                        error_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too many cycles without any beat or register write
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if ((byte_if.valid && byte_if.ready) || (result_if.valid && result_if.ready) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("wildcard_byte_pattern_scan_top regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        int phase;
        int i;

        cfg_we = 1'b0;
        cfg_index = CFG_PAT_LOW;
        cfg_data = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // overlap: pattern 41 41 42 against 41 41 41 42, the match starts at
        // offset 1 and lands on the range's last byte
        write_reg(CFG_PAT_LOW, 64'h0000_0000_0042_4141);
        write_reg(CFG_PAT_HIGH, 64'h0);
        write_reg(CFG_WILD_MASK, 64'h0);
        write_reg(CFG_PAT_LEN, 64'd3);
        write_reg(CFG_BASE_ADDR, 64'h1000);
        close_writes();
        add_pending('{8'h41, 1'b0});
        add_pending('{8'h41, 1'b0});
        add_pending('{8'h41, 1'b0});
        add_pending('{8'h42, 1'b1});
        // a new range: its match at offset 0 is reported, then the range end reports nothing
        add_pending('{8'h41, 1'b0});
        add_pending('{8'h41, 1'b0});
        add_pending('{8'h42, 1'b0});
        add_pending('{8'h00, 1'b1});
        bytes_queued += 8;
        wait_for_drain();

        // empty pattern never matches, the range ends in not found
        write_reg(CFG_PAT_LEN, 64'd0);
        close_writes();
        add_pending('{8'hAA, 1'b1});
        bytes_queued++;
        wait_for_drain();

        // start address wraps past the top of the address space
        write_reg(CFG_PAT_LOW, 64'h7E);
        write_reg(CFG_PAT_LEN, 64'd1);
        write_reg(CFG_BASE_ADDR, 64'hFFFF_FFFF_FFFF_FFFF);
        close_writes();
        add_pending('{8'h00, 1'b0});
        add_pending('{8'h7E, 1'b1});
        bytes_queued += 2;
        wait_for_drain();

        // register change in the middle of a range keeps the live prefix
        write_reg(CFG_PAT_LOW, 64'h2211);
        write_reg(CFG_PAT_LEN, 64'd2);
        write_reg(CFG_BASE_ADDR, 64'h8000_0000_0000_0000);
        close_writes();
        add_pending('{8'h11, 1'b0});
        bytes_queued++;
        wait_for_drain();
        write_reg(CFG_PAT_LOW, 64'h2233);
        close_writes();
        add_pending('{8'h22, 1'b1});
        bytes_queued++;
        wait_for_drain();

        // length 31 clamps to 16, all positions wildcards
        write_reg(CFG_PAT_HIGH, {$urandom, $urandom});
        write_reg(CFG_WILD_MASK, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_PAT_LEN, 64'hFFFF_FFFF_FFFF_FFFF);
        close_writes();
        for (i = 0; i < 16; i++)
            add_pending('{(i % 2 == 0) ? 8'h00 : 8'hFF, i == 15});
        bytes_queued += 16;
        wait_for_drain();

        // random phases: sender mostly busy and receiver slow, then the
        // reverse, then neither idles; each phase starts from a fresh setting
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase < 5)
            begin
                send_idle_pct = 14;
                recv_idle_pct = 77;
            end
            else if (phase < 10)
            begin
                send_idle_pct = 77;
                recv_idle_pct = 14;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            new_pattern();
            // backpressure: receiver holds off while the sender keeps going
            if (phase == 3 || phase == 12)
                hold_req++;
            fill_stream($urandom_range(150, 80));
            wait_for_drain();
        end

        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("scanned %0d bytes over %0d ranges and %0d register settings",
                 bytes_accepted, ranges_closed, settings_used);
        $display("%0d first matches, %0d ranges without a match, %0d mismatches",
                 first_matches, empty_ranges, error_count);
        if (error_count == 0 && expected_results.size() == 0)
            $display("wildcard_byte_pattern_scan_top regression: pass");
        else
            $display("wildcard_byte_pattern_scan_top regression: fail");
        $finish;
    end

endmodule
